[rtl/gshd_pkg.sv]
// Shared types, constants and helper functions for the controller link decoder.
// Used by gshd_frame_acc, gshd_link_ctrl and gamepad_serial_host_decoder.
package gshd_pkg;

    // Receiver limits
    localparam int MAX_SYMBOLS = 96;
    localparam int CNT_W       = 7;
    localparam int FRAME_W     = 64;
    localparam int NUM_AXES    = 6;
    localparam int TIME_W      = 15;

    // Response frame lengths in symbols
    localparam logic [CNT_W-1:0] PROBE_LEN  = CNT_W'(25);
    localparam logic [CNT_W-1:0] ORIGIN_LEN = CNT_W'(81);
    localparam logic [CNT_W-1:0] POLL_LEN   = CNT_W'(65);

    // Identity bytes accepted from the probe response
    localparam logic [7:0] ID_WIRED    = 8'h09;
    localparam logic [7:0] ID_WIRELESS = 8'hE9;

    // Configuration register reset values
    localparam logic [7:0] TIMEOUT_RST = 8'd25;
    localparam logic [7:0] CENTER_RST  = 8'd128;

    // Configuration register indexes
    typedef enum logic {
        CFG_TIMEOUT_LIMIT = 1'b0,
        CFG_STICK_CENTER  = 1'b1
    } cfg_idx_t;

    // Link phase; selects the next command the host sends
    typedef enum logic [1:0] {
        PH_PROBE  = 2'd0,
        PH_ORIGIN = 2'd1,
        PH_POLL   = 2'd2
    } phase_t;

    // Per-word control from the input stage
    typedef struct packed {
        logic sym_en;   // a pulse symbol is consumed
        logic win_en;   // a poll window end is consumed
        logic rcvd;     // window end: response frame completed
    } step_t;

    // Receiver state seen by the link controller
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic               first_level;
        logic [FRAME_W-1:0] bits;
    } frame_info_t;

    // Result word, packed so that the last field lands in the lowest bits
    typedef struct packed {
        logic [7:0]  trig_right;
        logic [7:0]  trig_left;
        logic [7:0]  right_y;
        logic [7:0]  right_x;
        logic [7:0]  left_y;
        logic [7:0]  left_x;
        logic [11:0] buttons;
        logic        new_report;
        logic [7:0]  device_id;
        logic        port_active;
        logic [1:0]  phase;
    } result_t;

    // Byte n of a frame: symbols 8n..8n+7, first symbol is the MSB
    function automatic logic [7:0] frame_byte(input logic [FRAME_W-1:0] bits, input int n);
        logic [7:0] v;
        v = '0;
        for (int j = 0; j < 8; j++)
        begin
            v[7-j] = bits[n*8+j];
        end
        return v;
    endfunction

    // Saturate a signed sum to 0..255
    function automatic logic [7:0] clamp_byte(input logic signed [9:0] v);
        logic [7:0] r;
        if (v < 0)
            r = 8'd0;
        else if (v > 10'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

[rtl/gshd_frame_acc.sv]
// Symbol accumulator: counts pulse symbols and collects decoded bits of a frame.
// Depends on gshd_pkg.
module gshd_frame_acc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gshd_pkg::step_t               step,
    input  logic [gshd_pkg::TIME_W-1:0]   low_time,
    input  logic [gshd_pkg::TIME_W-1:0]   high_time,
    input  logic                          starts_high,
    output gshd_pkg::frame_info_t         frame
);
    import gshd_pkg::*;

    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               level_reg,  level_next;
    logic [FRAME_W-1:0] bits_reg,   bits_next;

    // Next-state: accumulate on a symbol, rearm on any window end
    always_comb
    begin
        count_next = count_reg;
        level_next = level_reg;
        bits_next  = bits_reg;
        if (step.win_en)
        begin
            count_next = '0;
            level_next = 1'b0;
            bits_next  = '0;
        end
        else if (step.sym_en && (count_reg < CNT_W'(MAX_SYMBOLS)))
        begin
            if (count_reg == '0)
                level_next = starts_high;
            // a 1 bit when the low part is shorter than the high part
            if ((count_reg < CNT_W'(FRAME_W)) && (low_time < high_time))
                bits_next[count_reg[5:0]] = 1'b1;
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            level_reg <= 1'b0;
            bits_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            level_reg <= level_next;
            bits_reg  <= bits_next;
        end
    end

    assign frame.count       = count_reg;
    assign frame.first_level = level_reg;
    assign frame.bits        = bits_reg;

`ifndef SYNTHESIS
    // count saturates at the symbol limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SYMBOLS))
        else $error("symbol count beyond limit");

    // a window end rearms the receiver
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        step.win_en |=> (count_reg == '0) && (bits_reg == '0) && !level_reg)
        else $error("receiver not rearmed after window end");

    // the count holds while no word is consumed
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!step.sym_en && !step.win_en) |=> $stable(count_reg))
        else $error("symbol count moved without a word");
`endif

endmodule

[rtl/gshd_link_ctrl.sv]
// Link controller: phase tracking, missed-poll timeout, origin capture and reports.
// Depends on gshd_pkg; fed by gshd_frame_acc.
module gshd_link_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gshd_pkg::step_t       step,
    input  gshd_pkg::frame_info_t frame,
    input  logic [7:0]            timeout_limit,
    input  logic [7:0]            stick_center,
    output gshd_pkg::result_t     result
);
    import gshd_pkg::*;

    phase_t            phase_reg,   phase_next;
    logic              active_reg,  active_next;
    logic [7:0]        id_reg,      id_next;
    logic [7:0]        missed_reg,  missed_next;
    logic [11:0]       buttons_reg, buttons_next;
    logic signed [8:0] offset_reg [NUM_AXES];
    logic signed [8:0] offset_next [NUM_AXES];
    logic [7:0]        axis_reg  [NUM_AXES];
    logic [7:0]        axis_next [NUM_AXES];

    logic [7:0]        missed_inc;
    logic              timed_out;
    phase_t            phase_tmo;
    logic              active_tmo;
    logic              fresh;
    logic [7:0]        fbyte [NUM_AXES];
    logic [7:0]        id_byte;

    // Analog bytes 2..7 and the identity byte of the current frame
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            fbyte[i] = frame_byte(frame.bits, i + 2);
        end
        id_byte = frame_byte(frame.bits, 0);
    end

    // Window bookkeeping ahead of frame interpretation
    always_comb
    begin
        missed_inc = step.rcvd ? 8'd1 : missed_reg + 8'd1;
        timed_out  = (missed_inc >= timeout_limit);
        phase_tmo  = timed_out ? PH_PROBE : phase_reg;
        active_tmo = timed_out ? 1'b0 : active_reg;
    end

    // Frame interpretation by phase
    always_comb
    begin
        phase_next   = phase_tmo;
        active_next  = active_tmo;
        id_next      = id_reg;
        missed_next  = timed_out ? 8'd0 : missed_inc;
        buttons_next = buttons_reg;
        fresh        = 1'b0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            offset_next[i] = offset_reg[i];
            axis_next[i]   = axis_reg[i];
        end
        if (step.rcvd)
        begin
            case (phase_tmo)
                PH_ORIGIN:
                begin
                    if ((frame.count == ORIGIN_LEN) && !frame.bits[0] && !frame.bits[1])
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            offset_next[i] = $signed({1'b0, stick_center})
                                           - $signed({1'b0, fbyte[i]});
                        end
                        for (int i = 4; i < NUM_AXES; i++)
                        begin
                            offset_next[i] = -$signed({1'b0, fbyte[i]});
                        end
                        phase_next  = PH_POLL;
                        active_next = 1'b1;
                    end
                end
                PH_POLL:
                begin
                    if ((frame.count == POLL_LEN) && !frame.first_level)
                    begin
                        buttons_next = {frame.bits[9],  frame.bits[10], frame.bits[11],
                                        frame.bits[12], frame.bits[13], frame.bits[14],
                                        frame.bits[15], frame.bits[3],  frame.bits[4],
                                        frame.bits[5],  frame.bits[6],  frame.bits[7]};
                        for (int i = 0; i < NUM_AXES; i++)
                        begin
                            axis_next[i] = clamp_byte($signed({2'b00, fbyte[i]})
                                                      + 10'(offset_reg[i]));
                        end
                        fresh = 1'b1;
                    end
                end
                default:
                begin
                    // probe
                    if ((frame.count == PROBE_LEN)
                        && ((id_byte == ID_WIRED) || (id_byte == ID_WIRELESS)))
                    begin
                        id_next    = id_byte;
                        phase_next = PH_ORIGIN;
                    end
                end
            endcase
        end
    end

    // State update, only on a window end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PROBE;
            active_reg  <= 1'b0;
            id_reg      <= '0;
            missed_reg  <= '0;
            buttons_reg <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                offset_reg[i] <= '0;
                axis_reg[i]   <= '0;
            end
        end
        else if (step.win_en)
        begin
            phase_reg   <= phase_next;
            active_reg  <= active_next;
            id_reg      <= id_next;
            missed_reg  <= missed_next;
            buttons_reg <= buttons_next;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                offset_reg[i] <= offset_next[i];
                axis_reg[i]   <= axis_next[i];
            end
        end
    end

    // Result word for this window end
    always_comb
    begin
        result.phase       = phase_next;
        result.port_active = active_next;
        result.device_id   = id_next;
        result.new_report  = fresh;
        result.buttons     = buttons_next;
        result.left_x      = axis_next[0];
        result.left_y      = axis_next[1];
        result.right_x     = axis_next[2];
        result.right_y     = axis_next[3];
        result.trig_left   = axis_next[4];
        result.trig_right  = axis_next[5];
    end

`ifndef SYNTHESIS
    // the port is active exactly while polling
    a_active_poll: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == (phase_reg == PH_POLL))
        else $error("active flag out of step with phase");

    // only a known identity is ever stored
    a_id_known: assert property (@(posedge clk) disable iff (!rst_n)
        (id_reg == 8'd0) || (id_reg == ID_WIRED) || (id_reg == ID_WIRELESS))
        else $error("unknown device id stored");

    // a fresh report leaves the link in polling
    a_report_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (step.win_en && fresh) |=> (phase_reg == PH_POLL) && active_reg)
        else $error("report outside polling phase");
`endif

endmodule

[rtl/gamepad_serial_host_decoder.sv]
// Top level of the controller link decoder: input register, receiver, link
// controller and output register. Depends on gshd_pkg, gshd_frame_acc, gshd_link_ctrl.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tuser op; tdata symbol times and flags
//  m_*      | out       | m_tvalid/m_tready  | tdata one status/report word per window end
//  cfg_*    | in        | cfg_wr_en          | cfg_idx register, cfg_wdata value
//
// One word is taken per cycle unless a window-end word is stalled in the input register;
// the held word's state update and result are settled there, combinationally.
// A window-end word goes from the input register into the output register.
// Symbol words produce no result and keep flowing while a result waits; a
// window-end word waits in the input register only while the output is full.
// Reset (rst_n, asynchronous) returns to probe phase with the link state cleared.
module gamepad_serial_host_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,    // [0] op: 0 pulse symbol, 1 poll window end
    input  logic [31:0] s_tdata,    // [14:0] low_time, [29:15] high_time,
                                    // [30] starts_high, [31] frame_received
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [1:0] phase, [2] port_active, [10:3] device_id,
                                    // [11] new_report, [23:12] buttons, [31:24] left_x,
                                    // [39:32] left_y, [47:40] right_x, [55:48] right_y,
                                    // [63:56] trig_left, [71:64] trig_right
    input  logic        cfg_wr_en,
    input  logic        cfg_idx,
    input  logic [7:0]  cfg_wdata
);
    import gshd_pkg::*;

    logic        in_valid_reg;
    logic        in_op_reg;
    logic [31:0] in_data_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    logic [7:0]  timeout_limit_reg;
    logic [7:0]  stick_center_reg;

    logic        fire;
    step_t       step;
    frame_info_t frame;
    result_t     result;

    // Process the held word unless it is a window end facing a full output
    assign fire     = in_valid_reg && (!in_op_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    assign step.sym_en = fire && !in_op_reg;
    assign step.win_en = fire && in_op_reg;
    assign step.rcvd   = in_data_reg[31];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_limit_reg <= TIMEOUT_RST;
            stick_center_reg  <= CENTER_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_idx))
                CFG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_wdata;
                CFG_STICK_CENTER:  stick_center_reg  <= cfg_wdata;
                default:           timeout_limit_reg <= timeout_limit_reg;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    gshd_frame_acc u_frame_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .low_time    (in_data_reg[14:0]),
        .high_time   (in_data_reg[29:15]),
        .starts_high (in_data_reg[30]),
        .frame       (frame)
    );

    gshd_link_ctrl u_link_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .frame         (frame),
        .timeout_limit (timeout_limit_reg),
        .stick_center  (stick_center_reg),
        .result        (result)
    );

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step.win_en)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (step.win_en)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
